>>> hw/rtl/rapq_pkg.sv
// Package for the range-add / point-query table: sizes, field widths and opcodes.
// No dependencies; every other file in hw/rtl imports it.
package rapq_pkg;

  // Table geometry. BLOCK_SIZE must be a power of two (block index is a shift).
  localparam int ENTRIES    = 1024;
  localparam int BLOCK_SIZE = 32;
  localparam int NUM_BLOCKS = (ENTRIES + BLOCK_SIZE - 1) / BLOCK_SIZE;

  localparam int EA_W  = $clog2(ENTRIES);
  localparam int BLK_W = $clog2(BLOCK_SIZE);
  localparam int NB_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  // Beat field widths.
  localparam int OP_W  = 2;
  localparam int IDX_W = 10;
  localparam int AMT_W = 32;
  localparam int VAL_W = 64;

  typedef logic [OP_W-1:0]  op_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [AMT_W-1:0] amt_t;
  typedef logic [VAL_W-1:0] val_t;

  localparam op_t OP_LOAD  = 2'd0;
  localparam op_t OP_ADD   = 2'd1;
  localparam op_t OP_QUERY = 2'd2;

endpackage

>>> hw/rtl/rapq_in_if.sv
// Command channel interface: valid/ready handshake plus the command beat.
// Depends on rapq_pkg.
interface rapq_in_if;
  import rapq_pkg::*;

  logic                valid;
  logic                ready;
  op_t                 opcode;
  idx_t                first_index;
  idx_t                last_index;
  logic signed [AMT_W-1:0] amount;

  modport source (output valid, output opcode, output first_index,
                  output last_index, output amount, input ready);
  modport sink   (input valid, input opcode, input first_index,
                  input last_index, input amount, output ready);
endinterface

>>> hw/rtl/rapq_out_if.sv
// Result channel interface: valid/ready handshake plus the query result beat.
// Depends on rapq_pkg.
interface rapq_out_if;
  import rapq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] query_value;

  modport source (output valid, output query_value, input ready);
  modport sink   (input valid, input query_value, output ready);
endinterface

>>> hw/rtl/range_add_point_query_table_unit.sv
// Range-add / point-query table: entry memory, block-add memory and the sequencer.
// Depends on rapq_pkg, rapq_in_if and rapq_out_if.
//
// Usage:
//   in_ch carries command beats: load (write one base entry), range add (add an
//   amount to every entry of an inclusive index range) and point query. out_ch
//   carries one beat per point query: base entry plus pending block add (0 off table).
//   All arithmetic wraps at 64 bits; the amount is sign-extended.
// Sequencing:
//   Load: written on acceptance. Query: both memories read on acceptance, and the
//   sum is registered as the result once the slot frees. Range add: low partial
//   block entry by entry, then any whole blocks as pending-add words and the high
//   partial block, then a drain; one read-modify-write port per memory, one entry
//   or block per cycle. Empty adds (first > last, or first off the table) drop.
// Reset:
//   rst_n (synchronous, active low) idles the sequencer, drops any result and
//   clears the block-add valid bits, so every pending-add word reads as zero.
//   Entries are undefined until loaded.
// Stalls:
//   The result register holds a query beat while out_ch.ready is low; loads
//   and range adds keep flowing. A further query waits until the slot frees.
module range_add_point_query_table_unit (
  input  logic      clk,
  input  logic      rst_n,
  rapq_in_if.sink   in_ch,
  rapq_out_if.source out_ch
);
  import rapq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LO    = 3'd1;  // low partial block, entry by entry
  localparam logic [2:0] S_BLK   = 3'd2;  // whole blocks, pending-add words
  localparam logic [2:0] S_HI    = 3'd3;  // high partial block, entry by entry
  localparam logic [2:0] S_DRAIN = 3'd4;  // last write-back lands
  localparam logic [2:0] S_QRY   = 3'd5;  // query data ready, wait for slot

  // Memories
  val_t entry_mem [ENTRIES];
  val_t blk_mem   [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] blk_vld_r;

  // Sequencer state
  logic [2:0]      state_r, state_nxt;
  logic [EA_W-1:0] ptr_r, ptr_nxt;
  logic [EA_W-1:0] lo_end_r, lo_end_nxt;
  logic [EA_W-1:0] hi_r, hi_nxt;
  logic [NB_W-1:0] bptr_r, bptr_nxt;
  logic [NB_W-1:0] hb_r, hb_nxt;
  logic            single_r, single_nxt;
  logic            oob_r, oob_nxt;
  val_t            amt_r, amt_nxt;

  // Read ports and write-back stage
  logic            ent_rd_en;
  logic [EA_W-1:0] ent_rd_addr;
  val_t            ent_q_r;
  logic            ent_wb_vld_r;
  logic [EA_W-1:0] ent_wb_addr_r;
  logic            blk_rd_en;
  logic [NB_W-1:0] blk_rd_addr;
  val_t            blk_q_r;
  logic            blk_qv_r;
  logic            blk_wb_vld_r;
  logic [NB_W-1:0] blk_wb_addr_r;
  val_t            blk_cur;

  // Result register
  logic out_valid_r;
  val_t out_data_r;
  logic out_free;
  logic out_load;

  // Decoded command beat
  logic            accept;
  logic            lo_in_table;
  logic [EA_W-1:0] lo_a;
  logic [EA_W-1:0] hi_a;
  logic [NB_W-1:0] lb_a;
  logic [NB_W-1:0] hb_a;
  val_t            amt_ext;
  logic            load_we;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.query_value = out_data_r;

  assign lo_in_table = (32'(in_ch.first_index) < ENTRIES);
  assign lo_a        = EA_W'(in_ch.first_index);
  // Clamp the range end to the last entry of the table.
  assign hi_a = (32'(in_ch.last_index) >= ENTRIES) ? EA_W'(ENTRIES - 1)
                                                   : EA_W'(in_ch.last_index);
  assign lb_a    = NB_W'(lo_a >> BLK_W);
  assign hb_a    = NB_W'(hi_a >> BLK_W);
  assign amt_ext = {{(VAL_W-AMT_W){in_ch.amount[AMT_W-1]}}, in_ch.amount};
  assign load_we = accept && (in_ch.opcode == OP_LOAD) && lo_in_table;

  // Pending-add word of the block last read; unwritten words read as zero.
  assign blk_cur = blk_qv_r ? blk_q_r : '0;

  // Sequencer next state
  always_comb begin
    state_nxt  = state_r;
    ptr_nxt    = ptr_r;
    lo_end_nxt = lo_end_r;
    hi_nxt     = hi_r;
    bptr_nxt   = bptr_r;
    hb_nxt     = hb_r;
    single_nxt = single_r;
    oob_nxt    = oob_r;
    amt_nxt    = amt_r;
    ent_rd_en   = 1'b0;
    ent_rd_addr = ptr_r;
    blk_rd_en   = 1'b0;
    blk_rd_addr = bptr_r;
    out_load    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          amt_nxt = amt_ext;
          case (in_ch.opcode)
            OP_ADD: begin
              // Drop empty ranges at once.
              if (lo_in_table && (in_ch.first_index <= in_ch.last_index)) begin
                ptr_nxt    = lo_a;
                hi_nxt     = hi_a;
                bptr_nxt   = lb_a;
                hb_nxt     = hb_a;
                single_nxt = (lb_a == hb_a);
                lo_end_nxt = (lb_a == hb_a) ? hi_a
                           : ((EA_W'(lb_a) << BLK_W) | EA_W'(BLOCK_SIZE - 1));
                state_nxt  = S_LO;
              end
            end
            OP_QUERY: begin
              oob_nxt     = !lo_in_table;
              ent_rd_en   = 1'b1;
              ent_rd_addr = lo_a;
              blk_rd_en   = 1'b1;
              blk_rd_addr = lb_a;
              state_nxt   = S_QRY;
            end
            default: begin
            end
          endcase
        end
      end
      S_LO: begin
        ent_rd_en = 1'b1;
        if (ptr_r == lo_end_r) begin
          if (single_r) begin
            state_nxt = S_DRAIN;
          end else if ((bptr_r + NB_W'(1)) < hb_r) begin
            bptr_nxt  = bptr_r + NB_W'(1);
            state_nxt = S_BLK;
          end else begin
            ptr_nxt   = EA_W'(hb_r) << BLK_W;
            state_nxt = S_HI;
          end
        end else begin
          ptr_nxt = ptr_r + EA_W'(1);
        end
      end
      S_BLK: begin
        blk_rd_en = 1'b1;
        if ((bptr_r + NB_W'(1)) == hb_r) begin
          ptr_nxt   = EA_W'(hb_r) << BLK_W;
          state_nxt = S_HI;
        end else begin
          bptr_nxt = bptr_r + NB_W'(1);
        end
      end
      S_HI: begin
        ent_rd_en = 1'b1;
        if (ptr_r == hi_r) begin
          state_nxt = S_DRAIN;
        end else begin
          ptr_nxt = ptr_r + EA_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_IDLE;
      end
      S_QRY: begin
        // Read data holds until the result slot frees.
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ent_wb_vld_r <= 1'b0;
      blk_wb_vld_r <= 1'b0;
      out_valid_r  <= 1'b0;
      blk_vld_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      ent_wb_vld_r <= (state_r == S_LO) || (state_r == S_HI);
      blk_wb_vld_r <= (state_r == S_BLK);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (blk_wb_vld_r) begin
        blk_vld_r[blk_wb_addr_r] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ptr_r         <= ptr_nxt;
    lo_end_r      <= lo_end_nxt;
    hi_r          <= hi_nxt;
    bptr_r        <= bptr_nxt;
    hb_r          <= hb_nxt;
    single_r      <= single_nxt;
    oob_r         <= oob_nxt;
    amt_r         <= amt_nxt;
    ent_wb_addr_r <= ptr_r;
    blk_wb_addr_r <= bptr_r;
    if (out_load) begin
      out_data_r <= oob_r ? '0 : (ent_q_r + blk_cur);
    end
  end

  // Entry memory: one read, one write per cycle; write-back has priority.
  always_ff @(posedge clk) begin
    if (ent_rd_en) begin
      ent_q_r <= entry_mem[ent_rd_addr];
    end
    if (ent_wb_vld_r) begin
      entry_mem[ent_wb_addr_r] <= ent_q_r + amt_r;
    end else if (load_we) begin
      entry_mem[lo_a] <= amt_ext;
    end
  end

  // Block-add memory: valid bit read alongside the word.
  always_ff @(posedge clk) begin
    if (blk_rd_en) begin
      blk_q_r  <= blk_mem[blk_rd_addr];
      blk_qv_r <= blk_vld_r[blk_rd_addr];
    end
    if (blk_wb_vld_r) begin
      blk_mem[blk_wb_addr_r] <= blk_cur + amt_r;
    end
  end

  // Assertions
  a_no_wb_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(ent_wb_vld_r && (state_r == S_IDLE)) && !(blk_wb_vld_r && (state_r == S_IDLE)))
    else $error("write-back pending while sequencer idle");

  a_ent_rmw_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (ent_wb_vld_r && ent_rd_en) |-> (ent_rd_addr != ent_wb_addr_r))
    else $error("entry read overlaps pending write-back");

  a_blk_rmw_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (blk_wb_vld_r && blk_rd_en) |-> (blk_rd_addr != blk_wb_addr_r))
    else $error("block read overlaps pending write-back");

  a_query_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_QRY) && out_free) |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("query result not loaded when slot was free");

  a_lo_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LO) |-> (ptr_r <= lo_end_r))
    else $error("low partial walk ran past its end");

endmodule
